// ----- hdl/source_line_token_normalizer_unit_assert.svh -----
// Assertion macros for the source line token normalizer.
// Clocked on i_clk, disabled while i_rst_n is low; empty under SYNTHESIS.
`ifndef SOURCE_LINE_TOKEN_NORMALIZER_UNIT_ASSERT_SVH
`define SOURCE_LINE_TOKEN_NORMALIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SLNT_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define SLNT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SLNT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLNT_ASSERT_ALWAYS(lbl, expr, msg)
`define SLNT_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define SLNT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/slnt_pkg.sv -----
// Types and constants shared by the source line token normalizer.
// No dependencies.
`timescale 1ns / 1ps

package slnt_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_WORD    = 3'd1,
        MODE_DQUOTE  = 3'd2,
        MODE_SQUOTE  = 3'd3,
        MODE_COMMENT = 3'd4
    } t_mode;

    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_WORD_RESET = 8'h77;

    localparam int RESULT_DEPTH = 4;
    localparam int PTR_W        = $clog2(RESULT_DEPTH);
    localparam int CNT_W        = $clog2(RESULT_DEPTH + 1);

    typedef struct packed {
        t_mode mode;
        logic  slash_pending;
        logic  line_has_output;
    } t_scan_state;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       line_end;
        logic       line_empty;
    } t_result;

    typedef struct packed {
        logic [1:0]  count;
        t_result     res0;
        t_result     res1;
        t_scan_state next_state;
    } t_step_out;

endpackage

// ----- hdl/slnt_if.sv -----
// Valid/ready channel interfaces for the token normalizer input and output.
// No dependencies.
`timescale 1ns / 1ps

interface slnt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       line_last;

    modport source (output valid, output in_byte, output line_last, input ready);
    modport sink   (input valid, input in_byte, input line_last, output ready);
endinterface

interface slnt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       line_end;
    logic       line_empty;

    modport source (output valid, output out_char, output char_valid,
                    output line_end, output line_empty, input ready);
    modport sink   (input valid, input out_char, input char_valid,
                    input line_end, input line_empty, output ready);
endinterface

// ----- hdl/source_line_token_normalizer_unit.sv -----
// Source line token normalizer: top level with scan state and result queue.
// Depends on slnt_pkg, slnt_if.sv, slnt_token_step and the assertion header.
//
// Usage:
//   i_in carries one byte of a source line per transaction, with line_last
//   set on the final byte. o_out carries normalized characters: word runs
//   become the word marker, spaces and literal bodies drop, "//" drops the
//   rest of the line. The final result of a line has line_end set, and
//   line_empty when the line gave no character.
//   i_cfg_we/i_cfg_data write the word marker; write it only while idle.
//   Results are registered into the queue on accept; with the queue empty,
//   they show on the output in the next cycle. Throughput: one byte per
//   cycle while the queue has room; a byte yields zero, one or two results.
//   The output drains one result per ready cycle from a four-entry queue.
//   Stall: a byte is taken only while two or fewer results wait, so a
//   stalled receiver holds the input once three results are queued; bytes
//   that yield no result keep flowing until then.
//   Reset: scan state returns to normal mode, the queue empties and the
//   word marker returns to 'w'.
`timescale 1ns / 1ps

module source_line_token_normalizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slnt_in_if.sink    i_in,
    slnt_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);
    import slnt_pkg::*;
    `include "source_line_token_normalizer_unit_assert.svh"

    logic [7:0]       r_word_marker;
    t_scan_state      r_state;
    t_result          r_fifo [RESULT_DEPTH];
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [CNT_W-1:0] r_count;

    logic [PTR_W-1:0] n_rd_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [CNT_W-1:0] n_count;
    t_step_out        step;
    logic             accept;
    logic             pop;
    logic [1:0]       push_n;

    slnt_token_step u_step (
        .i_byte        (i_in.in_byte),
        .i_last        (i_in.line_last),
        .i_word_marker (r_word_marker),
        .i_state       (r_state),
        .o_step        (step)
    );

    // Take a byte only when two queue slots are guaranteed free.
    assign i_in.ready = (r_count <= CNT_W'(RESULT_DEPTH - 2));
    assign accept     = i_in.valid && i_in.ready;
    assign push_n     = accept ? step.count : 2'd0;
    assign pop        = o_out.valid && o_out.ready;

    assign o_out.valid      = (r_count != '0);
    assign o_out.out_char   = r_fifo[r_rd_ptr].out_char;
    assign o_out.char_valid = r_fifo[r_rd_ptr].char_valid;
    assign o_out.line_end   = r_fifo[r_rd_ptr].line_end;
    assign o_out.line_empty = r_fifo[r_rd_ptr].line_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(push_n);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop);
        n_count  = r_count + CNT_W'(push_n) - CNT_W'(pop);
    end

    // Control state: word marker, scan state, queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_marker <= CH_WORD_RESET;
            r_state       <= '{mode: MODE_NORMAL, slash_pending: 1'b0,
                               line_has_output: 1'b0};
            r_rd_ptr      <= '0;
            r_wr_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_word_marker <= i_cfg_data;
            end
            if (accept) begin
                r_state <= step.next_state;
            end
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    // Queue payload: first result at the write pointer, second right after.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= step.res0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= step.res1;
        end
    end

    `SLNT_ASSERT_ALWAYS(a_no_overflow, r_count <= CNT_W'(RESULT_DEPTH),
        "result queue overflow")
    `SLNT_ASSERT_IMPLIES(a_last_yields, accept && i_in.line_last, push_n != 2'd0,
        "line end lost")
    `SLNT_ASSERT_NEXT(a_line_reset, accept && i_in.line_last,
        r_state.mode == MODE_NORMAL && !r_state.slash_pending && !r_state.line_has_output,
        "scan state not cleared at line end")
    `SLNT_ASSERT_IMPLIES(a_slash_normal, r_state.slash_pending,
        r_state.mode == MODE_NORMAL, "held slash outside normal mode")

endmodule

// ----- hdl/slnt_token_step.sv -----
// Per-byte scanner step: next scan state and up to two results for one byte.
// Depends on slnt_pkg.
`timescale 1ns / 1ps

module slnt_token_step (
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic [7:0]           i_word_marker,
    input  slnt_pkg::t_scan_state i_state,
    output slnt_pkg::t_step_out  o_step
);
    import slnt_pkg::*;

    logic        is_word;
    logic        plain_emit;
    logic [7:0]  plain_char;
    t_mode       plain_mode;
    logic        plain_slash;
    logic        pre_v;
    logic        main_v;
    logic [7:0]  main_c;
    logic        has_out;
    t_scan_state nxt;

    assign is_word = (i_byte >= 8'h61 && i_byte <= 8'h7A) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h5A) ||
                     (i_byte >= 8'h30 && i_byte <= 8'h39) ||
                     (i_byte == CH_UNDERSCORE);

    // Byte seen in normal mode
    always_comb begin
        plain_emit  = 1'b0;
        plain_char  = i_byte;
        plain_mode  = MODE_NORMAL;
        plain_slash = 1'b0;
        priority if (i_byte == CH_SLASH) begin
            plain_slash = 1'b1;
        end else if (i_byte == CH_DQUOTE) begin
            plain_emit = 1'b1;
            plain_mode = MODE_DQUOTE;
        end else if (i_byte == CH_SQUOTE) begin
            plain_emit = 1'b1;
            plain_mode = MODE_SQUOTE;
        end else if (is_word) begin
            plain_emit = 1'b1;
            plain_char = i_word_marker;
            plain_mode = MODE_WORD;
        end else if (i_byte == CH_SPACE) begin
            plain_emit = 1'b0;
        end else begin
            plain_emit = 1'b1;
        end
    end

    always_comb begin
        nxt    = i_state;
        pre_v  = 1'b0;
        main_v = 1'b0;
        main_c = i_byte;
        unique case (i_state.mode)
            MODE_COMMENT: begin
                nxt.mode = MODE_COMMENT;
            end
            MODE_DQUOTE: begin
                if (i_byte == CH_DQUOTE) begin
                    main_v   = 1'b1;
                    nxt.mode = MODE_NORMAL;
                end
            end
            MODE_SQUOTE: begin
                if (i_byte == CH_SQUOTE) begin
                    main_v   = 1'b1;
                    nxt.mode = MODE_NORMAL;
                end
            end
            default: begin
                // Word mode swallows the rest of the run; anything else restarts.
                if (!(i_state.mode == MODE_WORD && is_word)) begin
                    nxt.mode = MODE_NORMAL;
                    if (i_state.slash_pending && i_byte == CH_SLASH) begin
                        nxt.slash_pending = 1'b0;
                        nxt.mode          = MODE_COMMENT;
                    end else begin
                        pre_v             = i_state.slash_pending;
                        main_v            = plain_emit;
                        main_c            = plain_char;
                        nxt.mode          = plain_mode;
                        nxt.slash_pending = plain_slash;
                    end
                end
            end
        endcase

        // A slash still held at line end is flushed; the main slot is free then.
        if (i_last && nxt.slash_pending) begin
            main_v = 1'b1;
            main_c = CH_SLASH;
        end

        has_out = i_state.line_has_output | pre_v | main_v;

        o_step.res0.out_char   = pre_v ? CH_SLASH : (main_v ? main_c : 8'h00);
        o_step.res0.char_valid = pre_v | main_v;
        o_step.res0.line_end   = i_last && !(pre_v && main_v);
        o_step.res0.line_empty = i_last && !(pre_v && main_v) && !has_out;
        o_step.res1.out_char   = main_c;
        o_step.res1.char_valid = 1'b1;
        o_step.res1.line_end   = i_last;
        o_step.res1.line_empty = 1'b0;

        priority if (pre_v && main_v) begin
            o_step.count = 2'd2;
        end else if (pre_v || main_v || i_last) begin
            o_step.count = 2'd1;
        end else begin
            o_step.count = 2'd0;
        end

        if (i_last) begin
            nxt.mode            = MODE_NORMAL;
            nxt.slash_pending   = 1'b0;
            nxt.line_has_output = 1'b0;
        end else begin
            nxt.line_has_output = has_out;
        end
        o_step.next_state = nxt;
    end

endmodule
